[src/twds_pkg.sv]
// ----------------------------------------------------------------------------
// twds_pkg
// Shared types, constants and the step program of the seed sequencer.
// ----------------------------------------------------------------------------
package twds_pkg;

  localparam int TILE_W_DEF       = 16;
  localparam int TILE_H_DEF       = 16;
  localparam int TILES_ACROSS_DEF = 64;
  localparam int TILES_DOWN_DEF   = 64;

  localparam int COORD_W   = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_STEPS = 65;
  localparam int STEP_W    = 7;
  localparam int NUM_ACC   = 13;
  localparam int ACC_W     = 4;
  localparam int NUM_MONO  = 7;

  // Steps spent on the origin corner (all seeds plus its polynomial value)
  localparam logic [STEP_W-1:0] STEPS_ORIGIN = 7'd35;
  localparam logic [STEP_W-1:0] STEPS_POLY   = 7'd10;

  // Coefficient index row*4 + col
  localparam logic [3:0] K00 = 4'd0;
  localparam logic [3:0] K01 = 4'd1;
  localparam logic [3:0] K02 = 4'd2;
  localparam logic [3:0] K03 = 4'd3;
  localparam logic [3:0] K10 = 4'd4;
  localparam logic [3:0] K11 = 4'd5;
  localparam logic [3:0] K12 = 4'd6;
  localparam logic [3:0] K20 = 4'd8;
  localparam logic [3:0] K21 = 4'd9;
  localparam logic [3:0] K30 = 4'd12;

  // Accumulator slots
  localparam logic [ACC_W-1:0] D_P0 = 4'd0;
  localparam logic [ACC_W-1:0] D_P1 = 4'd1;
  localparam logic [ACC_W-1:0] D_P2 = 4'd2;
  localparam logic [ACC_W-1:0] D_P3 = 4'd3;
  localparam logic [ACC_W-1:0] D_Q0 = 4'd4;
  localparam logic [ACC_W-1:0] D_Q1 = 4'd5;
  localparam logic [ACC_W-1:0] D_Q2 = 4'd6;
  localparam logic [ACC_W-1:0] D_R0 = 4'd7;
  localparam logic [ACC_W-1:0] D_R1 = 4'd8;
  localparam logic [ACC_W-1:0] D_S0 = 4'd9;
  localparam logic [ACC_W-1:0] D_C1 = 4'd10;
  localparam logic [ACC_W-1:0] D_C2 = 4'd11;
  localparam logic [ACC_W-1:0] D_C3 = 4'd12;

  typedef enum logic [4:0] {
    F_ONE, F_TWO, F_SIX, F_X, F_Y, F_X2, F_Y2, F_XY, F_X3, F_Y3, F_X2Y, F_XY2,
    F_6X1, F_2Y, F_3X2, F_2X1, F_2XYY, F_2X, F_6Y1, F_2XYX, F_3Y2, F_2Y1
  } fac_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MONO, ST_MAC, ST_DRAIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic               is_tile;
    logic [4:0]         addr;
    logic [DATA_W-1:0]  value;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } cmd_t;

  typedef struct packed {
    logic [ACC_W-1:0] dest;
    logic [3:0]       coef;
    fac_t             fac;
  } step_t;

  function automatic step_t mk(logic [ACC_W-1:0] d, logic [3:0] c, fac_t f);
    step_t s;
    s.dest = d;
    s.coef = c;
    s.fac  = f;
    return s;
  endfunction

  function automatic step_t poly_step(logic [ACC_W-1:0] d, logic [3:0] k);
    step_t s;
    case (k)
      4'd0:    s = mk(d, K00, F_ONE);
      4'd1:    s = mk(d, K30, F_X3);
      4'd2:    s = mk(d, K03, F_Y3);
      4'd3:    s = mk(d, K21, F_X2Y);
      4'd4:    s = mk(d, K12, F_XY2);
      4'd5:    s = mk(d, K20, F_X2);
      4'd6:    s = mk(d, K11, F_XY);
      4'd7:    s = mk(d, K02, F_Y2);
      4'd8:    s = mk(d, K10, F_X);
      default: s = mk(d, K01, F_Y);
    endcase
    return s;
  endfunction

  // Step program: seeds and origin value, then the other three corners.
  function automatic step_t step_at(logic [STEP_W-1:0] n);
    step_t s;
    case (n)
      7'd0:  s = mk(D_P0, K30, F_SIX);
      7'd1:  s = mk(D_P1, K30, F_6X1);
      7'd2:  s = mk(D_P1, K21, F_2Y);
      7'd3:  s = mk(D_P1, K20, F_TWO);
      7'd4:  s = mk(D_P2, K30, F_3X2);
      7'd5:  s = mk(D_P2, K20, F_2X1);
      7'd6:  s = mk(D_P2, K21, F_2XYY);
      7'd7:  s = mk(D_P2, K12, F_Y2);
      7'd8:  s = mk(D_P2, K11, F_Y);
      7'd9:  s = mk(D_P2, K10, F_ONE);
      7'd10: s = mk(D_Q0, K03, F_SIX);
      7'd11: s = mk(D_Q1, K12, F_2X);
      7'd12: s = mk(D_Q1, K03, F_6Y1);
      7'd13: s = mk(D_Q1, K02, F_TWO);
      7'd14: s = mk(D_Q2, K21, F_X2);
      7'd15: s = mk(D_Q2, K12, F_2XYX);
      7'd16: s = mk(D_Q2, K03, F_3Y2);
      7'd17: s = mk(D_Q2, K11, F_X);
      7'd18: s = mk(D_Q2, K02, F_2Y1);
      7'd19: s = mk(D_Q2, K01, F_ONE);
      7'd20: s = mk(D_R0, K12, F_TWO);
      7'd21: s = mk(D_R1, K21, F_2X1);
      7'd22: s = mk(D_R1, K12, F_2Y1);
      7'd23: s = mk(D_R1, K11, F_ONE);
      7'd24: s = mk(D_S0, K21, F_TWO);
      default: begin
        if (n < 7'd35)      s = poly_step(D_P3, 4'(n - 7'd25));
        else if (n < 7'd45) s = poly_step(D_C1, 4'(n - 7'd35));
        else if (n < 7'd55) s = poly_step(D_C2, 4'(n - 7'd45));
        else                s = poly_step(D_C3, 4'(n - 7'd55));
      end
    endcase
    return s;
  endfunction

endpackage

[src/twds_if.sv]
// ----------------------------------------------------------------------------
// twds_in_if / twds_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface twds_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               coeff_axis;
  logic [1:0]         coeff_row;
  logic [1:0]         coeff_col;
  logic signed [31:0] coeff_value;
  logic [5:0]         tile_x;
  logic [5:0]         tile_y;

  modport source(output valid, op, coeff_axis, coeff_row, coeff_col, coeff_value,
                 tile_x, tile_y, input ready);
  modport sink(input valid, op, coeff_axis, coeff_row, coeff_col, coeff_value,
               tile_x, tile_y, output ready);
endinterface

interface twds_out_if;
  logic               valid;
  logic               ready;
  logic               is_y_axis;
  logic signed [31:0] p_third_diff;
  logic signed [31:0] p_second_diff;
  logic signed [31:0] p_first_diff;
  logic signed [31:0] poly_value;
  logic signed [31:0] q_third_diff;
  logic signed [31:0] q_second_diff;
  logic signed [31:0] q_first_diff;
  logic signed [31:0] r_const_diff;
  logic signed [31:0] r_var_diff;
  logic signed [31:0] s_const_diff;
  logic signed [31:0] cache_start;

  modport source(output valid, is_y_axis, p_third_diff, p_second_diff, p_first_diff,
                 poly_value, q_third_diff, q_second_diff, q_first_diff, r_const_diff,
                 r_var_diff, s_const_diff, cache_start, input ready);
  modport sink(input valid, is_y_axis, p_third_diff, p_second_diff, p_first_diff,
               poly_value, q_third_diff, q_second_diff, q_first_diff, r_const_diff,
               r_var_diff, s_const_diff, cache_start, output ready);
endinterface

[src/twds_front.sv]
// ----------------------------------------------------------------------------
// twds_front
// Classify a request into a table write or a tile command with corners.
// ----------------------------------------------------------------------------
module twds_front #(
  parameter int TILE_W       = twds_pkg::TILE_W_DEF,
  parameter int TILE_H       = twds_pkg::TILE_H_DEF,
  parameter int TILES_ACROSS = twds_pkg::TILES_ACROSS_DEF,
  parameter int TILES_DOWN   = twds_pkg::TILES_DOWN_DEF
) (
  input  logic              op,
  input  logic              coeff_axis,
  input  logic [1:0]        coeff_row,
  input  logic [1:0]        coeff_col,
  input  logic [31:0]       coeff_value,
  input  logic [5:0]        tile_x,
  input  logic [5:0]        tile_y,
  output twds_pkg::cmd_t    cmd
);
  localparam logic [15:0] TW    = 16'(TILE_W);
  localparam logic [15:0] TH    = 16'(TILE_H);
  localparam logic [15:0] LIM_X = 16'(TILES_ACROSS);
  localparam logic [15:0] LIM_Y = 16'(TILES_DOWN);

  logic [15:0] tx, ty, x0, y0;

  always_comb begin
    tx = {10'd0, tile_x};
    ty = {10'd0, tile_y};
    // clamp to the last tile
    if (tx >= LIM_X) tx = LIM_X - 16'd1;
    if (ty >= LIM_Y) ty = LIM_Y - 16'd1;
    x0 = 16'(tx * TW);
    y0 = 16'(ty * TH);
    cmd.is_tile = op;
    cmd.addr    = {coeff_axis, coeff_row, coeff_col};
    cmd.value   = coeff_value;
    cmd.x0      = x0;
    cmd.y0      = y0;
    cmd.x1      = x0 + TW - 16'd1;
    cmd.y1      = y0 + TH - 16'd1;
  end
endmodule

[src/twds_queue.sv]
// ----------------------------------------------------------------------------
// twds_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module twds_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  twds_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output twds_pkg::cmd_t  pop_data
);
  twds_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end
endmodule

[src/twds_back.sv]
// ----------------------------------------------------------------------------
// twds_back
// Coefficient table and multiply-accumulate sequencer for the tile seeds.
// ----------------------------------------------------------------------------
module twds_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  twds_pkg::cmd_t  cmd,
  twds_out_if.source      res
);
  twds_pkg::state_t state_r, state_nxt;
  logic             axis_r, axis_nxt;
  logic [1:0]       corner_r, corner_nxt;
  logic [2:0]       mstep_r, mstep_nxt;
  logic [twds_pkg::STEP_W-1:0] step_r, step_nxt;

  logic [15:0] x0_r, x1_r, y0_r, y1_r;
  logic [15:0] mx_r, my_r, mx2_r, my2_r, mxy_r, mx3_r, my3_r, mx2y_r, mxy2_r;

  logic [31:0] coef_r [32];
  logic [31:0] acc_r  [twds_pkg::NUM_ACC];
  logic [31:0] prod_r;
  logic [twds_pkg::ACC_W-1:0] pdest_r;
  logic        pvld_r;

  logic        out_valid_r, out_axis_r;
  logic [31:0] out_v_r [11];

  // control decoded by the sequencer
  logic        tbl_we, clr_acc, load_corner, mono_go, mac_go, emit;
  logic [twds_pkg::STEP_W-1:0] corner_end;

  twds_pkg::step_t st;
  logic [15:0] fac, ma, mb, mp;
  logic [31:0] coef_rd, best;
  logic [31:0] full_prod;

  function automatic logic [15:0] factor(twds_pkg::fac_t f, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] x2, logic [15:0] y2, logic [15:0] xy,
                                         logic [15:0] x3, logic [15:0] y3, logic [15:0] x2y,
                                         logic [15:0] xy2);
    logic [15:0] r;
    case (f)
      twds_pkg::F_ONE:  r = 16'd1;
      twds_pkg::F_TWO:  r = 16'd2;
      twds_pkg::F_SIX:  r = 16'd6;
      twds_pkg::F_X:    r = x;
      twds_pkg::F_Y:    r = y;
      twds_pkg::F_X2:   r = x2;
      twds_pkg::F_Y2:   r = y2;
      twds_pkg::F_XY:   r = xy;
      twds_pkg::F_X3:   r = x3;
      twds_pkg::F_Y3:   r = y3;
      twds_pkg::F_X2Y:  r = x2y;
      twds_pkg::F_XY2:  r = xy2;
      twds_pkg::F_6X1:  r = 16'(x * 16'd6) + 16'd6;
      twds_pkg::F_2Y:   r = {y[14:0], 1'b0};
      twds_pkg::F_3X2:  r = 16'(x2 * 16'd3) + 16'(x * 16'd3) + 16'd1;
      twds_pkg::F_2X1:  r = {x[14:0], 1'b1};
      twds_pkg::F_2XYY: r = {xy[14:0], 1'b0} + y;
      twds_pkg::F_2X:   r = {x[14:0], 1'b0};
      twds_pkg::F_6Y1:  r = 16'(y * 16'd6) + 16'd6;
      twds_pkg::F_2XYX: r = {xy[14:0], 1'b0} + x;
      twds_pkg::F_3Y2:  r = 16'(y2 * 16'd3) + 16'(y * 16'd3) + 16'd1;
      twds_pkg::F_2Y1:  r = {y[14:0], 1'b1};
      default:          r = 16'd0;
    endcase
    return r;
  endfunction

  assign st         = twds_pkg::step_at(step_r);
  assign coef_rd    = coef_r[{axis_r, st.coef}];
  assign fac        = factor(st.fac, mx_r, my_r, mx2_r, my2_r, mxy_r, mx3_r, my3_r,
                             mx2y_r, mxy2_r);
  assign full_prod  = 32'($signed(fac) * $signed(coef_rd));
  assign corner_end = twds_pkg::STEPS_ORIGIN - 7'd1 +
                      7'(twds_pkg::STEPS_POLY * {5'd0, corner_r});

  // monomial multiplier operands
  always_comb begin
    case (mstep_r)
      3'd0:    begin ma = mx_r;  mb = mx_r; end
      3'd1:    begin ma = my_r;  mb = my_r; end
      3'd2:    begin ma = mx_r;  mb = my_r; end
      3'd3:    begin ma = mx2_r; mb = mx_r; end
      3'd4:    begin ma = my2_r; mb = my_r; end
      3'd5:    begin ma = mx2_r; mb = my_r; end
      default: begin ma = mx_r;  mb = my2_r; end
    endcase
    mp = 16'(ma * mb);
  end

  // cache start: earliest corner kept on equal integer parts
  always_comb begin
    best = acc_r[twds_pkg::D_P3];
    if ($signed(acc_r[twds_pkg::D_C1][31:16]) < $signed(best[31:16]))
      best = acc_r[twds_pkg::D_C1];
    if ($signed(acc_r[twds_pkg::D_C2][31:16]) < $signed(best[31:16]))
      best = acc_r[twds_pkg::D_C2];
    if ($signed(acc_r[twds_pkg::D_C3][31:16]) < $signed(best[31:16]))
      best = acc_r[twds_pkg::D_C3];
  end

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    corner_nxt  = corner_r;
    mstep_nxt   = mstep_r;
    step_nxt    = step_r;
    cmd_ready   = 1'b0;
    tbl_we      = 1'b0;
    clr_acc     = 1'b0;
    load_corner = 1'b0;
    mono_go     = 1'b0;
    mac_go      = 1'b0;
    emit        = 1'b0;
    case (state_r)
      twds_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_tile) begin
            state_nxt   = twds_pkg::ST_MONO;
            axis_nxt    = 1'b0;
            corner_nxt  = 2'd0;
            mstep_nxt   = 3'd0;
            step_nxt    = '0;
            clr_acc     = 1'b1;
            load_corner = 1'b1;
          end else begin
            tbl_we = 1'b1;
          end
        end
      end
      twds_pkg::ST_MONO: begin
        mono_go   = 1'b1;
        mstep_nxt = mstep_r + 3'd1;
        if (mstep_r == 3'(twds_pkg::NUM_MONO - 1)) state_nxt = twds_pkg::ST_MAC;
      end
      twds_pkg::ST_MAC: begin
        mac_go   = 1'b1;
        step_nxt = step_r + 7'd1;
        if (step_r == corner_end) begin
          if (corner_r == 2'd3) begin
            state_nxt = twds_pkg::ST_DRAIN;
          end else begin
            state_nxt   = twds_pkg::ST_MONO;
            corner_nxt  = corner_r + 2'd1;
            mstep_nxt   = 3'd0;
            load_corner = 1'b1;
          end
        end
      end
      twds_pkg::ST_DRAIN: begin
        state_nxt = twds_pkg::ST_EMIT;
      end
      twds_pkg::ST_EMIT: begin
        if (!out_valid_r || res.ready) begin
          emit = 1'b1;
          if (!axis_r) begin
            state_nxt   = twds_pkg::ST_MONO;
            axis_nxt    = 1'b1;
            corner_nxt  = 2'd0;
            mstep_nxt   = 3'd0;
            step_nxt    = '0;
            clr_acc     = 1'b1;
            load_corner = 1'b1;
          end else begin
            state_nxt = twds_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = twds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twds_pkg::ST_IDLE;
      axis_r      <= 1'b0;
      corner_r    <= 2'd0;
      mstep_r     <= 3'd0;
      step_r      <= '0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 32; i++) coef_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      corner_r <= corner_nxt;
      mstep_r  <= mstep_nxt;
      step_r   <= step_nxt;
      pvld_r   <= mac_go;
      if (tbl_we) coef_r[cmd.addr] <= cmd.value;
      if (emit)                   out_valid_r <= 1'b1;
      else if (res.ready)         out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.is_tile) begin
      x0_r <= cmd.x0;
      x1_r <= cmd.x1;
      y0_r <= cmd.y0;
      y1_r <= cmd.y1;
    end
    if (load_corner) begin
      // upper left, upper right, lower left, lower right
      if (state_r == twds_pkg::ST_IDLE) begin
        mx_r <= cmd.x0;
        my_r <= cmd.y0;
      end else begin
        mx_r <= corner_nxt[0] ? x1_r : x0_r;
        my_r <= corner_nxt[1] ? y1_r : y0_r;
      end
    end
    if (mono_go) begin
      case (mstep_r)
        3'd0:    mx2_r  <= mp;
        3'd1:    my2_r  <= mp;
        3'd2:    mxy_r  <= mp;
        3'd3:    mx3_r  <= mp;
        3'd4:    my3_r  <= mp;
        3'd5:    mx2y_r <= mp;
        default: mxy2_r <= mp;
      endcase
    end
    if (mac_go) begin
      prod_r  <= full_prod;
      pdest_r <= st.dest;
    end
    if (clr_acc) begin
      for (int i = 0; i < twds_pkg::NUM_ACC; i++) acc_r[i] <= '0;
    end else if (pvld_r) begin
      acc_r[pdest_r] <= acc_r[pdest_r] + prod_r;
    end
    if (emit) begin
      out_axis_r  <= axis_r;
      out_v_r[0]  <= acc_r[twds_pkg::D_P0];
      out_v_r[1]  <= acc_r[twds_pkg::D_P1];
      out_v_r[2]  <= acc_r[twds_pkg::D_P2];
      out_v_r[3]  <= acc_r[twds_pkg::D_P3];
      out_v_r[4]  <= acc_r[twds_pkg::D_Q0];
      out_v_r[5]  <= acc_r[twds_pkg::D_Q1];
      out_v_r[6]  <= acc_r[twds_pkg::D_Q2];
      out_v_r[7]  <= acc_r[twds_pkg::D_R0];
      out_v_r[8]  <= acc_r[twds_pkg::D_R1];
      out_v_r[9]  <= acc_r[twds_pkg::D_S0];
      out_v_r[10] <= best;
    end
  end

  assign res.valid         = out_valid_r;
  assign res.is_y_axis     = out_axis_r;
  assign res.p_third_diff  = out_v_r[0];
  assign res.p_second_diff = out_v_r[1];
  assign res.p_first_diff  = out_v_r[2];
  assign res.poly_value    = out_v_r[3];
  assign res.q_third_diff  = out_v_r[4];
  assign res.q_second_diff = out_v_r[5];
  assign res.q_first_diff  = out_v_r[6];
  assign res.r_const_diff  = out_v_r[7];
  assign res.r_var_diff    = out_v_r[8];
  assign res.s_const_diff  = out_v_r[9];
  assign res.cache_start   = out_v_r[10];
endmodule

[src/tile_warp_difference_setup_top.sv]
// ----------------------------------------------------------------------------
// tile_warp_difference_setup_top
// Forward-difference seed setup for a cubic X/Y warp, per tile.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests. op = 0 writes one signed 16.16 coefficient of the
//   X or Y cubic mapping into a 32-entry table and returns nothing.
//   op = 1 names a tile; the block returns two results on out_ch, X axis
//   first, then Y axis (is_y_axis high marks the last of the pair).
//   Requests pass a classifier into a two-entry command queue, so in_ch
//   keeps taking requests while the back end computes or out_ch stalls.
//   Coefficient writes retire one per cycle while the back end is idle. A
//   tile runs on one shared 16x32 multiply-accumulate unit: per axis 4
//   corners x 7 monomial steps plus 65 accumulate steps, then a drain
//   step and an emit step; the tile command is taken once for both axes.
//   A stalled out_ch holds the result register; the back end waits in its
//   emit step and the queue fills, then in_ch.ready drops.
//   Reset (rst_n low, synchronous) clears the table to zero, empties the
//   queue and drops out_ch.valid.
// ----------------------------------------------------------------------------
module tile_warp_difference_setup_top #(
  parameter int TILE_W       = twds_pkg::TILE_W_DEF,
  parameter int TILE_H       = twds_pkg::TILE_H_DEF,
  parameter int TILES_ACROSS = twds_pkg::TILES_ACROSS_DEF,
  parameter int TILES_DOWN   = twds_pkg::TILES_DOWN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  twds_in_if.sink     in_ch,
  twds_out_if.source  out_ch
);
  twds_pkg::cmd_t front_cmd, queue_cmd;
  logic           queue_valid, queue_ready;

  // classify the request: table write or tile with corner coordinates
  twds_front #(
    .TILE_W       (TILE_W),
    .TILE_H       (TILE_H),
    .TILES_ACROSS (TILES_ACROSS),
    .TILES_DOWN   (TILES_DOWN)
  ) u_front (
    .op          (in_ch.op),
    .coeff_axis  (in_ch.coeff_axis),
    .coeff_row   (in_ch.coeff_row),
    .coeff_col   (in_ch.coeff_col),
    .coeff_value (in_ch.coeff_value),
    .tile_x      (in_ch.tile_x),
    .tile_y      (in_ch.tile_y),
    .cmd         (front_cmd)
  );

  // decouple request intake from the sequencer
  twds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  // table writes and seed computation, in request order
  twds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .res       (out_ch)
  );
endmodule
